[rtl/triangle_unit_normal_assert.svh]
// Assertion macros used by the checker of the triangle normal unit.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH
// Same-cycle implication, disabled while reset is asserted.
`define TUN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define TUN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[rtl/tun_pkg.sv]
// Shared types of the triangle normal unit.
// No dependencies.
`default_nettype none
package tun_pkg;
	// Control that travels alongside a request through the pipeline.
	typedef struct packed {
		logic       valid;
		logic       deg;
		logic [2:0] neg;
	} tun_ctl_t;
endpackage
`default_nettype wire

[rtl/tun_front.sv]
// Front end: edges, cross product, squares and squared length, six stages.
// Depends on tun_pkg.
`default_nettype none
module tun_front #(
	parameter int C  = 16,
	parameter int F  = 14,
	parameter int LW = 70,
	parameter int WW = 103
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_vld,
	output logic                        in_rdy,
	input  wire logic signed [C-1:0]    p [9],
	output tun_pkg::tun_ctl_t           ctl,
	output logic [WW-1:0]               e_o [3],
	output logic [LW-1:0]               len2_o,
	input  wire logic                   nxt_rdy
);
	localparam int DW = C + 1;
	localparam int PW = 2 * DW;
	localparam int NW = PW + 1;
	localparam int MW = PW;
	localparam int HW = DW;
	localparam int SW = 2 * MW;

	logic [6:1] v_q;
	logic [6:1] en;

	logic signed [DW-1:0] a_s1 [3];
	logic signed [DW-1:0] b_s1 [3];
	logic signed [PW-1:0] pr_s2 [6];
	logic [MW-1:0]        m_s3 [3];
	logic [2:0]           neg_s3, neg_s4, neg_s5, neg_s6;
	logic [2*HW-1:0]      hh_s4 [3];
	logic [2*HW-1:0]      hl_s4 [3];
	logic [2*HW-1:0]      ll_s4 [3];
	logic                 deg_s4, deg_s5, deg_s6;
	logic [SW-1:0]        sq_s5 [3];
	logic [LW-1:0]        len2_s6;
	logic [WW-1:0]        e_s6 [3];

	assign en[6] = !v_q[6] || nxt_rdy;
	assign en[5] = !v_q[5] || en[6];
	assign en[4] = !v_q[4] || en[5];
	assign en[3] = !v_q[3] || en[4];
	assign en[2] = !v_q[2] || en[3];
	assign en[1] = !v_q[1] || en[2];
	assign in_rdy = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= in_vld;
			if (en[2]) v_q[2] <= v_q[1];
			if (en[3]) v_q[3] <= v_q[2];
			if (en[4]) v_q[4] <= v_q[3];
			if (en[5]) v_q[5] <= v_q[4];
			if (en[6]) v_q[6] <= v_q[5];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= $signed({p[i][C-1], p[i]}) - $signed({p[3+i][C-1], p[3+i]});
				b_s1[i] <= $signed({p[3+i][C-1], p[3+i]})
					- $signed({p[6+i][C-1], p[6+i]});
			end
		end
		if (en[2]) begin
			pr_s2[0] <= a_s1[1] * b_s1[2];
			pr_s2[1] <= a_s1[2] * b_s1[1];
			pr_s2[2] <= a_s1[2] * b_s1[0];
			pr_s2[3] <= a_s1[0] * b_s1[2];
			pr_s2[4] <= a_s1[0] * b_s1[1];
			pr_s2[5] <= a_s1[1] * b_s1[0];
		end
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [NW-1:0] n;
				n = $signed({pr_s2[2*i][PW-1], pr_s2[2*i]})
					- $signed({pr_s2[2*i+1][PW-1], pr_s2[2*i+1]});
				neg_s3[i] <= n[NW-1];
				m_s3[i]   <= n[NW-1] ? MW'(-n) : MW'(n);
			end
		end
		if (en[4]) begin
			for (int i = 0; i < 3; i++) begin
				hh_s4[i] <= m_s3[i][MW-1:HW] * m_s3[i][MW-1:HW];
				hl_s4[i] <= m_s3[i][MW-1:HW] * m_s3[i][HW-1:0];
				ll_s4[i] <= m_s3[i][HW-1:0] * m_s3[i][HW-1:0];
			end
			neg_s4 <= neg_s3;
			deg_s4 <= (m_s3[0] == '0) && (m_s3[1] == '0) && (m_s3[2] == '0);
		end
		if (en[5]) begin
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= (SW'(hh_s4[i]) << (2 * HW)) + (SW'(hl_s4[i]) << (HW + 1))
					+ SW'(ll_s4[i]);
			end
			neg_s5 <= neg_s4;
			deg_s5 <= deg_s4;
		end
		if (en[6]) begin
			len2_s6 <= LW'(sq_s5[0]) + LW'(sq_s5[1]) + LW'(sq_s5[2]);
			for (int i = 0; i < 3; i++) begin
				e_s6[i] <= WW'(sq_s5[i]) << (2 * F + 2);
			end
			neg_s6 <= neg_s5;
			deg_s6 <= deg_s5;
		end
	end

	assign ctl.valid = v_q[6];
	assign ctl.deg   = deg_s6;
	assign ctl.neg   = neg_s6;
	assign e_o       = e_s6;
	assign len2_o    = len2_s6;
endmodule
`default_nettype wire

[rtl/tun_cell.sv]
// One cell of the square-root-of-quotient chain: settles one bit of x for all
// three components. Depends on tun_pkg.
`default_nettype none
module tun_cell #(
	parameter int LW  = 70,
	parameter int WW  = 103,
	parameter int XW  = 16,
	parameter int BIT = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tun_pkg::tun_ctl_t ctl_i,
	input  wire logic [WW-1:0]     e_i [3],
	input  wire logic [WW-1:0]     p_i [3],
	input  wire logic [XW-1:0]     x_i [3],
	input  wire logic [LW-1:0]     len2_i,
	output logic                   rdy,
	output tun_pkg::tun_ctl_t      ctl_o,
	output logic [WW-1:0]          e_o [3],
	output logic [WW-1:0]          p_o [3],
	output logic [XW-1:0]          x_o [3],
	output logic [LW-1:0]          len2_o,
	input  wire logic              nxt_rdy
);
	localparam int TW = WW + 1;

	logic               v_q;
	tun_pkg::tun_ctl_t  ctl_q;
	logic [WW-1:0]      e_q [3];
	logic [WW-1:0]      p_q [3];
	logic [XW-1:0]      x_q [3];
	logic [LW-1:0]      len2_q;

	assign rdy = !v_q || nxt_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy) begin
			v_q <= ctl_i.valid;
		end
	end

	// Trial term (x + 2^BIT)^2 L - x^2 L = 2^(BIT+1) xL + 2^(2 BIT) L.
	always_ff @(posedge clk) begin
		if (rdy) begin
			for (int i = 0; i < 3; i++) begin
				logic [TW-1:0] t;
				t = (TW'(p_i[i]) << (BIT + 1)) + (TW'(len2_i) << (2 * BIT));
				if (TW'(e_i[i]) >= t) begin
					e_q[i] <= WW'(TW'(e_i[i]) - t);
					p_q[i] <= p_i[i] + (WW'(len2_i) << BIT);
					x_q[i] <= x_i[i] | (XW'(1) << BIT);
				end else begin
					e_q[i] <= e_i[i];
					p_q[i] <= p_i[i];
					x_q[i] <= x_i[i];
				end
			end
			ctl_q  <= ctl_i;
			len2_q <= len2_i;
		end
	end

	always_comb begin
		ctl_o       = ctl_q;
		ctl_o.valid = v_q;
	end
	assign e_o    = e_q;
	assign p_o    = p_q;
	assign x_o    = x_q;
	assign len2_o = len2_q;
endmodule
`default_nettype wire

[rtl/triangle_unit_normal.sv]
// Path: the front stages, then one cell per bit of x, then the output register.
// Throughput: one triangle per cycle while out_stall is low; every stage and cell is a pipeline step.
// Reset: arst_n clears all valid flags asynchronously; data registers keep junk.
// Depends on tun_pkg, tun_front and tun_cell.
`default_nettype none
// The unit forms the edges p0-p1 and p1-p2, their exact cross product n and
// the squared length L = |n|^2. For each component it then finds
// x = floor(sqrt(|n_i|^2 * 2^(2F+2) / L)) one bit per cell, keeping the
// remainder E = R - x^2 L and the running product P = x L, so that each cell
// needs only shifts, wide adds and subtracts, and one compare. The rounded result is
// r = (x + 1) / 2, which is the nearest value with ties away from zero.
// Handshake readiness ripples back through the chain, so a free cell takes
// a request even while the output register still holds a result.
module triangle_unit_normal #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 14
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [COORD_BITS-1:0]  p0_x,
	input  wire logic signed [COORD_BITS-1:0]  p0_y,
	input  wire logic signed [COORD_BITS-1:0]  p0_z,
	input  wire logic signed [COORD_BITS-1:0]  p1_x,
	input  wire logic signed [COORD_BITS-1:0]  p1_y,
	input  wire logic signed [COORD_BITS-1:0]  p1_z,
	input  wire logic signed [COORD_BITS-1:0]  p2_x,
	input  wire logic signed [COORD_BITS-1:0]  p2_y,
	input  wire logic signed [COORD_BITS-1:0]  p2_z,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [FRAC_BITS+1:0]        norm_x,
	output logic signed [FRAC_BITS+1:0]        norm_y,
	output logic signed [FRAC_BITS+1:0]        norm_z,
	output logic                               degenerate
);
	localparam int C  = COORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int MW = 2 * C + 2;
	localparam int LW = 2 * MW + 2;
	localparam int WW = LW + 2 * F + 5;
	localparam int XW = F + 2;
	localparam int OW = F + 2;
	localparam int NC = F + 2;

	logic signed [C-1:0] pts [9];
	logic                front_rdy;

	tun_pkg::tun_ctl_t cc [NC+1];
	logic [WW-1:0]     ce [NC+1][3];
	logic [WW-1:0]     cp [NC+1][3];
	logic [XW-1:0]     cx [NC+1][3];
	logic [LW-1:0]     cl [NC+1];
	logic [NC:0]       cr;

	logic              ov_q;
	logic              out_rdy;
	logic [OW-1:0]     nx_q, ny_q, nz_q;
	logic              deg_q;
	logic [OW-1:0]     res [3];

	assign pts[0] = p0_x;
	assign pts[1] = p0_y;
	assign pts[2] = p0_z;
	assign pts[3] = p1_x;
	assign pts[4] = p1_y;
	assign pts[5] = p1_z;
	assign pts[6] = p2_x;
	assign pts[7] = p2_y;
	assign pts[8] = p2_z;

	tun_front #(.C(C), .F(F), .LW(LW), .WW(WW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (in_valid),
		.in_rdy  (front_rdy),
		.p       (pts),
		.ctl     (cc[0]),
		.e_o     (ce[0]),
		.len2_o  (cl[0]),
		.nxt_rdy (cr[0])
	);
	assign in_stall = !front_rdy;

	// The chain starts with x = 0 and P = 0.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cp[0][i] = '0;
			cx[0][i] = '0;
		end
	end

	// Cell k settles bit NC-1-k of x, most significant bit first.
	for (genvar k = 0; k < NC; k++) begin : g_cell
		tun_cell #(.LW(LW), .WW(WW), .XW(XW), .BIT(NC - 1 - k)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_i   (cc[k]),
			.e_i     (ce[k]),
			.p_i     (cp[k]),
			.x_i     (cx[k]),
			.len2_i  (cl[k]),
			.rdy     (cr[k]),
			.ctl_o   (cc[k+1]),
			.e_o     (ce[k+1]),
			.p_o     (cp[k+1]),
			.x_o     (cx[k+1]),
			.len2_o  (cl[k+1]),
			.nxt_rdy (cr[k+1])
		);
	end

	// Rounding, sign and the degenerate case are applied at the output register.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [XW:0] r;
			r = ({1'b0, cx[NC][i]} + (XW + 1)'(1)) >> 1;
			if (cc[NC].deg) begin
				res[i] = '0;
			end else if (cc[NC].neg[i]) begin
				res[i] = OW'(-r);
			end else begin
				res[i] = OW'(r);
			end
		end
	end

	assign out_rdy = !ov_q || !out_stall;
	assign cr[NC]  = out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_rdy) begin
			ov_q <= cc[NC].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			nx_q  <= res[0];
			ny_q  <= res[1];
			nz_q  <= res[2];
			deg_q <= cc[NC].deg;
		end
	end

	assign out_valid  = ov_q;
	assign norm_x     = nx_q;
	assign norm_y     = ny_q;
	assign norm_z     = nz_q;
	assign degenerate = deg_q;
endmodule
`default_nettype wire

[rtl/tun_checker.sv]
// Port-level checks on the triangle normal unit, bound to its top level.
// Depends on triangle_unit_normal_assert.svh.
`default_nettype none
`include "triangle_unit_normal_assert.svh"
module tun_checker #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 14
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic [COORD_BITS-1:0]        p0_x,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic signed [FRAC_BITS+1:0]  norm_x,
	input wire logic signed [FRAC_BITS+1:0]  norm_y,
	input wire logic signed [FRAC_BITS+1:0]  norm_z,
	input wire logic                         degenerate
);
	localparam logic signed [FRAC_BITS+1:0] ONE = (FRAC_BITS + 2)'(1) << FRAC_BITS;

	`TUN_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(norm_x) && $stable(norm_y) && $stable(norm_z) && $stable(degenerate), "stalled result changed")
	`TUN_ASSERT_IMP(a_deg_zero, out_valid && degenerate, norm_x == '0 && norm_y == '0 && norm_z == '0, "degenerate result is not zero")
	`TUN_ASSERT_IMP(a_unit_nz, out_valid && !degenerate, norm_x != '0 || norm_y != '0 || norm_z != '0, "normal of a proper triangle is zero")
	`TUN_ASSERT_IMP(a_range, out_valid, norm_x <= ONE && norm_x >= -ONE && norm_y <= ONE && norm_y >= -ONE && norm_z <= ONE && norm_z >= -ONE, "component beyond one")

	// Unused port-level signals are kept for binding by name.
	logic unused_ok;
	assign unused_ok = in_valid ^ in_stall ^ (^p0_x);
endmodule

bind triangle_unit_normal tun_checker #(
	.COORD_BITS(COORD_BITS),
	.FRAC_BITS (FRAC_BITS)
) u_tun_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.p0_x       (p0_x),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.norm_x     (norm_x),
	.norm_y     (norm_y),
	.norm_z     (norm_z),
	.degenerate (degenerate)
);
`default_nettype wire
